[hw/rtl/ebl_pkg.sv]
// ----------------------------------------------------------------------------
// ebl_pkg
// Shared types and constants for the epsilon-greedy bandit learner.
// ----------------------------------------------------------------------------
package ebl_pkg;

    localparam int MAX_ARMS_DEF = 8;

    localparam int EST_W   = 16;
    localparam int RATE_W  = 16;
    localparam int COUNT_W = 4;
    localparam int OUT_ARM_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ARMS_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd2;

    localparam logic [COUNT_W-1:0] ARMS_RST = 4'd3;
    localparam logic [RATE_W-1:0]  EXPLORE_RST = 16'd6554;
    localparam logic [RATE_W-1:0]  LEARN_RST   = 16'd6554;

    // item function codes
    localparam logic FUNC_DECIDE = 1'b0;
    localparam logic FUNC_REWARD = 1'b1;

    // control part of the token walking down the cell chain
    typedef struct packed {
        logic valid;
        logic scan;   // greedy compare in this walk
        logic wr;     // selected cell loads wdata
        logic found;  // some arm beat zero and all earlier arms
    } t_tok_ctl;

    typedef struct packed {
        logic signed [EST_W-1:0] best;
        logic signed [EST_W-1:0] fdata;  // estimate picked up at the selected cell
        logic signed [EST_W-1:0] wdata;
    } t_tok_data;

endpackage

[hw/rtl/epsilon_greedy_bandit_learner.sv]
// ----------------------------------------------------------------------------
// epsilon_greedy_bandit_learner
// Epsilon-greedy bandit learner: per-arm Q8.8 estimates kept in a chain of
// cells, one token walking the chain per lookup, a read and a write token per update.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   func, uniform_draw, explore_arm, reward_value
//  out       source     o_out_valid / i_out_stall chosen_arm, explored, estimate
//  cfg       sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
//  decide item: result valid after one walk of the chain
//  reward item: result valid after the read walk, multiply, add and write walk
//  one item at a time; the next is taken while the result still waits
//  reset is synchronous and clears all estimates and remembered arms at once
//  a stalled result holds in the output register; the chain is not stalled
// ----------------------------------------------------------------------------
module epsilon_greedy_bandit_learner #(
    parameter int MAX_ARMS = ebl_pkg::MAX_ARMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [15:0]                        i_uniform_draw,
    input  logic [2:0]                         i_explore_arm,
    input  logic signed [15:0]                 i_reward_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_chosen_arm,
    output logic                               o_explored,
    output logic signed [15:0]                 o_estimate,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ebl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ebl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_ARMS);

    logic [ebl_pkg::COUNT_W-1:0] r_arms_in_use;
    logic [ebl_pkg::RATE_W-1:0]  r_explore_rate;
    logic [ebl_pkg::RATE_W-1:0]  r_learn_rate;

    logic [ebl_pkg::COUNT_W-1:0] w_arms_lo;
    logic [ebl_pkg::COUNT_W-1:0] w_n;

    ebl_pkg::t_tok_ctl  w_ctl  [MAX_ARMS+1];
    ebl_pkg::t_tok_data w_data [MAX_ARMS+1];
    logic [AW-1:0]      w_sel  [MAX_ARMS+1];
    logic [AW-1:0]      w_bidx [MAX_ARMS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arms_in_use  <= ebl_pkg::ARMS_RST;
            r_explore_rate <= ebl_pkg::EXPLORE_RST;
            r_learn_rate   <= ebl_pkg::LEARN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ebl_pkg::CFG_ARMS_IN_USE:  r_arms_in_use  <= i_cfg_data[ebl_pkg::COUNT_W-1:0];
                ebl_pkg::CFG_EXPLORE_RATE: r_explore_rate <= i_cfg_data;
                ebl_pkg::CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // arm count limited to 1 .. MAX_ARMS
    assign w_arms_lo = (r_arms_in_use == '0) ? 4'd1 : r_arms_in_use;
    assign w_n = (32'(w_arms_lo) > 32'(MAX_ARMS)) ? ebl_pkg::COUNT_W'(MAX_ARMS) : w_arms_lo;

    assign w_bidx[0] = '0;

    ebl_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (w_n),
        .i_explore_rate (r_explore_rate),
        .i_learn_rate   (r_learn_rate),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_uniform_draw (i_uniform_draw),
        .i_explore_arm  (i_explore_arm),
        .i_reward_value (i_reward_value),
        .o_inj_ctl      (w_ctl[0]),
        .o_inj_data     (w_data[0]),
        .o_inj_sel      (w_sel[0]),
        .i_ret_ctl      (w_ctl[MAX_ARMS]),
        .i_ret_data     (w_data[MAX_ARMS]),
        .i_ret_bidx     (w_bidx[MAX_ARMS]),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_chosen_arm   (o_chosen_arm),
        .o_explored     (o_explored),
        .o_estimate     (o_estimate)
    );

    for (genvar g = 0; g < MAX_ARMS; g++) begin : g_cell
        ebl_cell #(
            .IDX (g),
            .AW  (AW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_n     (w_n),
            .i_ctl   (w_ctl[g]),
            .i_data  (w_data[g]),
            .i_sel   (w_sel[g]),
            .i_bidx  (w_bidx[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_data  (w_data[g+1]),
            .o_sel   (w_sel[g+1]),
            .o_bidx  (w_bidx[g+1])
        );
    end

endmodule

[hw/rtl/ebl_cell.sv]
// ----------------------------------------------------------------------------
// ebl_cell
// One arm: holds its estimate, joins the greedy compare and serves the
// read or write of the token that passes through it.
// ----------------------------------------------------------------------------
module ebl_cell #(
    parameter int IDX = 0,
    parameter int AW  = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ebl_pkg::COUNT_W-1:0]    i_n,
    input  ebl_pkg::t_tok_ctl              i_ctl,
    input  ebl_pkg::t_tok_data             i_data,
    input  logic [AW-1:0]                  i_sel,
    input  logic [AW-1:0]                  i_bidx,
    output ebl_pkg::t_tok_ctl              o_ctl,
    output ebl_pkg::t_tok_data             o_data,
    output logic [AW-1:0]                  o_sel,
    output logic [AW-1:0]                  o_bidx
);

    localparam logic [7:0]    IDX8  = 8'(IDX);
    localparam logic [AW-1:0] IDX_A = AW'(IDX);

    logic signed [ebl_pkg::EST_W-1:0] r_est;
    ebl_pkg::t_tok_ctl                r_ctl;
    ebl_pkg::t_tok_data               r_data;
    logic [AW-1:0]                    r_sel;
    logic [AW-1:0]                    r_bidx;

    ebl_pkg::t_tok_ctl  n_ctl;
    ebl_pkg::t_tok_data n_data;
    logic [AW-1:0]      n_bidx;
    logic               w_hit;
    logic               w_beat;

    assign w_hit  = i_ctl.valid && (i_sel == IDX_A);
    assign w_beat = i_ctl.valid && i_ctl.scan && (IDX8 < {4'b0, i_n})
                    && (r_est > i_data.best);

    always_comb begin
        n_ctl  = i_ctl;
        n_data = i_data;
        n_bidx = i_bidx;
        if (w_beat) begin
            n_data.best = r_est;
            n_bidx      = IDX_A;
            n_ctl.found = 1'b1;
        end
        if (w_hit) begin
            n_data.fdata = r_est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (w_hit && i_ctl.wr) begin
                r_est <= i_data.wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_sel  <= i_sel;
        r_bidx <= n_bidx;
    end

    assign o_ctl  = r_ctl;
    assign o_data = r_data;
    assign o_sel  = r_sel;
    assign o_bidx = r_bidx;

endmodule

[hw/rtl/ebl_ctrl.sv]
// ----------------------------------------------------------------------------
// ebl_ctrl
// Sequencer: takes items, launches tokens into the cell chain, blends
// rewards and holds the result register.
// ----------------------------------------------------------------------------
module ebl_ctrl #(
    parameter int AW = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ebl_pkg::COUNT_W-1:0]         i_n,
    input  logic [ebl_pkg::RATE_W-1:0]          i_explore_rate,
    input  logic [ebl_pkg::RATE_W-1:0]          i_learn_rate,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [15:0]                         i_uniform_draw,
    input  logic [2:0]                          i_explore_arm,
    input  logic signed [15:0]                  i_reward_value,
    output ebl_pkg::t_tok_ctl                   o_inj_ctl,
    output ebl_pkg::t_tok_data                  o_inj_data,
    output logic [AW-1:0]                       o_inj_sel,
    input  ebl_pkg::t_tok_ctl                   i_ret_ctl,
    input  ebl_pkg::t_tok_data                  i_ret_data,
    input  logic [AW-1:0]                       i_ret_bidx,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ebl_pkg::OUT_ARM_W-1:0]       o_chosen_arm,
    output logic                                o_explored,
    output logic signed [ebl_pkg::EST_W-1:0]    o_estimate
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_ADD,
        S_WB,
        S_DONE
    } t_state;

    t_state                            r_state;
    ebl_pkg::t_tok_ctl                 r_inj_ctl;
    ebl_pkg::t_tok_data                r_inj_data;
    logic [AW-1:0]                     r_sel;
    logic [AW-1:0]                     r_last_greedy;
    logic [AW-1:0]                     r_last_chosen;
    logic                              r_func;
    logic                              r_explored;
    logic signed [ebl_pkg::EST_W-1:0]  r_reward;
    logic signed [ebl_pkg::EST_W-1:0]  r_q;
    logic signed [33:0]                r_prod;
    logic [AW-1:0]                     r_res_arm;
    logic signed [ebl_pkg::EST_W-1:0]  r_res_est;
    logic                              r_out_valid;
    logic [ebl_pkg::OUT_ARM_W-1:0]     r_out_arm;
    logic                              r_out_explored;
    logic signed [ebl_pkg::EST_W-1:0]  r_out_est;

    ebl_pkg::t_tok_ctl                 n_inj_ctl;
    logic                              n_out_valid;

    logic                              w_accept;
    logic                              w_exploit;
    logic [ebl_pkg::COUNT_W-1:0]       w_rarm;
    logic [AW-1:0]                     w_clamped;
    logic signed [16:0]                w_diff;
    logic signed [16:0]                w_rate;
    logic signed [33:0]                w_mul;
    logic signed [34:0]                w_sum;
    logic signed [ebl_pkg::EST_W-1:0]  w_new;
    logic                              w_out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_exploit  = (i_func == ebl_pkg::FUNC_DECIDE) && (i_uniform_draw >= i_explore_rate);

    // explore arm clamped to the top arm in use
    assign w_rarm    = {1'b0, i_explore_arm};
    assign w_clamped = (w_rarm >= i_n) ? AW'(i_n - 4'd1) : AW'(w_rarm);

    // R*a + Q*(65536-a) == Q*65536 + (R-Q)*a
    assign w_diff = $signed({r_reward[15], r_reward}) - $signed({r_q[15], r_q});
    assign w_rate = $signed({1'b0, i_learn_rate});
    assign w_mul  = w_diff * w_rate;
    assign w_sum  = $signed({{3{r_q[15]}}, r_q, 16'b0}) + $signed({r_prod[33], r_prod});
    assign w_new  = w_sum[31:16];

    // read token on accept, write token once the blend is ready
    always_comb begin
        n_inj_ctl = '0;
        if (w_accept) begin
            n_inj_ctl.valid = 1'b1;
            n_inj_ctl.scan  = w_exploit;
        end else if (r_state == S_ADD) begin
            n_inj_ctl.valid = 1'b1;
            n_inj_ctl.wr    = 1'b1;
        end
    end

    assign n_out_valid = ((r_state == S_DONE) && w_out_free) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_inj_ctl     <= '0;
            r_last_greedy <= '0;
            r_last_chosen <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_inj_ctl   <= n_inj_ctl;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func     <= i_func;
                        r_reward   <= i_reward_value;
                        r_inj_data <= '0;
                        r_state    <= S_WALK;
                        if (i_func == ebl_pkg::FUNC_REWARD) begin
                            r_sel      <= r_last_chosen;
                            r_explored <= 1'b0;
                        end else if (i_uniform_draw < i_explore_rate) begin
                            r_sel      <= w_clamped;
                            r_explored <= 1'b1;
                        end else begin
                            // fetch the old greedy arm in case nobody qualifies
                            r_sel      <= r_last_greedy;
                            r_explored <= 1'b0;
                        end
                    end
                end
                S_WALK: begin
                    if (i_ret_ctl.valid) begin
                        if (r_func == ebl_pkg::FUNC_REWARD) begin
                            r_q     <= i_ret_data.fdata;
                            r_state <= S_MUL;
                        end else begin
                            if (i_ret_ctl.found) begin
                                r_res_arm     <= i_ret_bidx;
                                r_res_est     <= i_ret_data.best;
                                r_last_greedy <= i_ret_bidx;
                                r_last_chosen <= i_ret_bidx;
                            end else begin
                                r_res_arm     <= r_sel;
                                r_res_est     <= i_ret_data.fdata;
                                r_last_chosen <= r_sel;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_inj_data.wdata <= w_new;
                    r_res_arm        <= r_sel;
                    r_res_est        <= w_new;
                    r_state          <= S_WB;
                end
                S_WB: begin
                    if (i_ret_ctl.valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_arm      <= ebl_pkg::OUT_ARM_W'(r_res_arm);
                        r_out_explored <= r_explored;
                        r_out_est      <= r_res_est;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_inj_ctl    = r_inj_ctl;
    assign o_inj_data   = r_inj_data;
    assign o_inj_sel    = r_sel;
    assign o_out_valid  = r_out_valid;
    assign o_chosen_arm = r_out_arm;
    assign o_explored   = r_out_explored;
    assign o_estimate   = r_out_est;

    a_ret_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ret_ctl.valid |-> (r_state == S_WALK || r_state == S_WB))
        else $error("token returned while no walk was pending");

    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inj_ctl.valid |=> !r_inj_ctl.valid)
        else $error("two tokens launched back to back");

    a_accept_launches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_inj_ctl.valid && !r_inj_ctl.wr))
        else $error("accepted item did not launch a read walk");

    a_write_after_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inj_ctl.valid && r_inj_ctl.wr) |-> (r_state == S_WB && $past(r_state) == S_ADD))
        else $error("write token launched outside the reward update");

endmodule
